/* rtl/mfsc_pkg.sv */
// shared types, constants and helper functions for the magic frame sniffer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package mfsc_pkg;

    // sizes of the frame layout
    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int MAGIC_LEN       = 8;
    localparam int HEAD_END        = 16;
    localparam int CRC_LEN         = 4;
    localparam int TDATA_W         = 96;

    // protocol constants
    localparam logic [7:0]  PROTO_VERSION = 8'h01;
    localparam logic [7:0]  MAGIC_FIRST   = 8'hA5;
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;

    // what one input byte does to the stream
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_PASS,
        ACT_FRAME,
        ACT_REPLAY
    } act_t;

    // controller states
    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_REPLAY,
        ST_FLUSH
    } state_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [31:0] pass_data;
        logic [2:0]  pass_count;
        logic [7:0]  frame_command;
        logic [31:0] frame_sequence;
        logic [6:0]  frame_length;
        logic [7:0]  frame_first_payload;
        logic        last;
    } res_t;

    // datapath status toward the controller
    typedef struct packed {
        act_t action;
        logic rd_group_start;
        logic rd_group_end;
        logic rd_done;
    } dp_stat_t;

    // controller commands toward the datapath
    typedef struct packed {
        logic accept;
        logic rd_issue;
    } ctrl_cmd_t;

    // magic sequence A5 5A E S C 3 2 !
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'hA5;
            3'd1:    b = 8'h5A;
            3'd2:    b = 8'h45;
            3'd3:    b = 8'h53;
            3'd4:    b = 8'h43;
            3'd5:    b = 8'h33;
            3'd6:    b = 8'h32;
            3'd7:    b = 8'h21;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // reflected crc-32, one byte per call
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'b0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/magic_frame_sniffer_crc32_unit.sv */
// command frame sniffer: one byte per accepted request; a passthrough byte or a
// frame event is pushed into the output queue in the same cycle its byte is accepted
// throughput one byte per cycle while the queue has room and no replay runs;
// a failed frame replays its held bytes, four to a result, from the single-port
// held byte memory, no input taken; asynchronous active-low reset clears control
// state and the crc; the held byte memory is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module magic_frame_sniffer_crc32_unit
#(
    parameter int MAX_PAYLOAD = mfsc_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pass_data, pass_count, frame_command, frame_sequence, frame_length,
    // frame_first_payload, zero pad
    output logic [mfsc_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser,   // kind
    output logic                          m_tlast    // last
);

    mfsc_pkg::dp_stat_t   stat;
    mfsc_pkg::ctrl_cmd_t  cmd;
    mfsc_pkg::res_t       push_res;
    mfsc_pkg::res_t       head;
    logic                 push;
    logic                 fifo_full;

    // controller
    mfsc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .fifo_full (fifo_full),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    mfsc_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .push     (push),
        .push_res (push_res)
    );

    // result queue
    mfsc_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .pop_ready (m_tready),
        .full      (fifo_full),
        .valid     (m_tvalid),
        .head      (head)
    );

    // output packing
    assign m_tdata = {6'b0, head.frame_first_payload, head.frame_length,
                      head.frame_sequence, head.frame_command,
                      head.pass_count, head.pass_data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

/* rtl/mfsc_ctrl.sv */
// controller state machine: input handshake and replay sequencing
// depends on mfsc_pkg
`timescale 1ns / 1ps

module mfsc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 fifo_full,
    input  mfsc_pkg::dp_stat_t   stat,
    output mfsc_pkg::ctrl_cmd_t  cmd
);

    mfsc_pkg::state_t state_reg;
    mfsc_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfsc_pkg::ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mfsc_pkg::ST_ACCEPT:
            begin
                if (s_tvalid && !fifo_full && stat.action == mfsc_pkg::ACT_REPLAY)
                begin
                    state_next = mfsc_pkg::ST_REPLAY;
                end
            end
            mfsc_pkg::ST_REPLAY:
            begin
                if (cmd.rd_issue && stat.rd_group_end)
                begin
                    state_next = mfsc_pkg::ST_FLUSH;
                end
            end
            mfsc_pkg::ST_FLUSH:
            begin
                state_next = stat.rd_done ? mfsc_pkg::ST_ACCEPT : mfsc_pkg::ST_REPLAY;
            end
            default:
            begin
                state_next = mfsc_pkg::ST_ACCEPT;
            end
        endcase
    end

    // outputs: take bytes only with a free queue slot, start a group only with one too
    always_comb
    begin
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rd_issue = 1'b0;
        case (state_reg)
            mfsc_pkg::ST_ACCEPT:
            begin
                s_tready   = !fifo_full;
                cmd.accept = s_tvalid && !fifo_full;
            end
            mfsc_pkg::ST_REPLAY:
            begin
                cmd.rd_issue = !stat.rd_group_start || !fifo_full;
            end
            mfsc_pkg::ST_FLUSH:
            begin
                cmd.rd_issue = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/mfsc_outq.sv */
// two-entry result queue between the datapath and the output stream
// depends on mfsc_pkg
`timescale 1ns / 1ps

module mfsc_outq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mfsc_pkg::res_t   push_res,
    input  logic             pop_ready,
    output logic             full,
    output logic             valid,
    output mfsc_pkg::res_t   head
);

    mfsc_pkg::res_t slot0_reg;
    mfsc_pkg::res_t slot1_reg;
    logic [1:0]     count_reg;
    logic           pop;

    assign valid = (count_reg != 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot0_reg;
    assign pop   = valid && pop_ready;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // slot data
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= (push && count_reg == 2'd1) ? push_res : slot1_reg;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_res;
            end
            else
            begin
                slot1_reg <= push_res;
            end
        end
    end

`ifndef SYNTH
    // a request never lands in a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into full queue");

    // a lone pop frees one slot
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue count wrong after pop");
`endif

endmodule

/* rtl/mfsc_dp.sv */
// datapath: magic match, header decode, crc, held byte memory, replay packer
// depends on mfsc_pkg
`timescale 1ns / 1ps

module mfsc_dp
#(
    parameter int MAX_PAYLOAD = mfsc_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  mfsc_pkg::ctrl_cmd_t  cmd,
    output mfsc_pkg::dp_stat_t   stat,
    output logic                 push,
    output mfsc_pkg::res_t       push_res
);

    localparam int HOLD_DEPTH = MAX_PAYLOAD + mfsc_pkg::HEAD_END + mfsc_pkg::CRC_LEN;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int ADDR_W     = $clog2(HOLD_DEPTH);

    // held byte memory
    logic [7:0] mem [HOLD_DEPTH];

    logic [CNT_W-1:0]  held_count_reg,  held_count_next;
    logic [CNT_W-1:0]  frame_total_reg, frame_total_next;
    logic [CNT_W-1:0]  replay_len_reg,  replay_len_next;
    logic [CNT_W-1:0]  rd_addr_reg;
    logic [31:0]       crc_reg,   crc_next;
    logic [63:0]       hdr_reg,   hdr_next;
    logic [31:0]       tail_reg,  tail_next;
    logic [7:0]        first_reg, first_next;
    logic [7:0]        rd_byte_reg;
    logic              rd_vld_reg;
    logic [1:0]        rd_lane_reg;
    logic              rd_end_reg;
    logic              rd_last_reg;
    logic [31:0]       pack_reg,  pack_next;

    logic [CNT_W-1:0]  held_inc;
    logic [31:0]       crc_fed;
    logic [31:0]       wire_crc;
    logic [15:0]       hdr_len;
    logic              mem_we;
    logic              rd_last;
    mfsc_pkg::act_t    action;
    mfsc_pkg::res_t    acc_res;
    mfsc_pkg::res_t    rep_res;

    assign held_inc = held_count_reg + CNT_W'(1);
    assign crc_fed  = mfsc_pkg::crc_byte(crc_reg, rx_byte);
    assign wire_crc = {rx_byte, tail_reg[31:8]};
    assign hdr_len  = hdr_reg[31:16];
    assign rd_last  = (rd_addr_reg + CNT_W'(1) == replay_len_reg);

    // byte classification and frame tracking
    always_comb
    begin
        held_count_next  = held_count_reg;
        frame_total_next = frame_total_reg;
        replay_len_next  = replay_len_reg;
        crc_next         = crc_reg;
        hdr_next         = hdr_reg;
        tail_next        = tail_reg;
        first_next       = first_reg;
        mem_we           = 1'b0;
        action           = mfsc_pkg::ACT_HOLD;
        if (held_count_reg < CNT_W'(mfsc_pkg::MAGIC_LEN))
        begin
            if (rx_byte == mfsc_pkg::magic_byte(held_count_reg[2:0]))
            begin
                mem_we          = 1'b1;
                held_count_next = held_inc;
            end
            else if (held_count_reg == '0)
            begin
                action = mfsc_pkg::ACT_PASS;
            end
            else if (rx_byte == mfsc_pkg::MAGIC_FIRST)
            begin
                // entry zero already holds the first magic byte
                action          = mfsc_pkg::ACT_REPLAY;
                replay_len_next = held_count_reg;
                held_count_next = CNT_W'(1);
            end
            else
            begin
                mem_we          = 1'b1;
                action          = mfsc_pkg::ACT_REPLAY;
                replay_len_next = held_inc;
                held_count_next = '0;
            end
        end
        else
        begin
            mem_we          = 1'b1;
            held_count_next = held_inc;
            tail_next       = wire_crc;
            if (held_inc <= CNT_W'(mfsc_pkg::HEAD_END))
            begin
                crc_next = crc_fed;
                hdr_next[8 * held_count_reg[2:0] +: 8] = rx_byte;
                if (held_inc == CNT_W'(mfsc_pkg::HEAD_END))
                begin
                    if (hdr_reg[7:0] != mfsc_pkg::PROTO_VERSION
                        || {1'b0, hdr_len} > 17'(MAX_PAYLOAD))
                    begin
                        action          = mfsc_pkg::ACT_REPLAY;
                        replay_len_next = held_inc;
                        held_count_next = '0;
                        crc_next        = mfsc_pkg::CRC_INIT;
                    end
                    else
                    begin
                        frame_total_next = CNT_W'(hdr_len)
                            + CNT_W'(mfsc_pkg::HEAD_END + mfsc_pkg::CRC_LEN);
                    end
                end
            end
            else
            begin
                if (held_inc == CNT_W'(mfsc_pkg::HEAD_END + 1))
                begin
                    first_next = rx_byte;
                end
                if (held_inc <= frame_total_reg - CNT_W'(mfsc_pkg::CRC_LEN))
                begin
                    crc_next = crc_fed;
                end
                if (held_inc == frame_total_reg)
                begin
                    crc_next        = mfsc_pkg::CRC_INIT;
                    held_count_next = '0;
                    if (~crc_reg != wire_crc)
                    begin
                        action          = mfsc_pkg::ACT_REPLAY;
                        replay_len_next = held_inc;
                    end
                    else
                    begin
                        action = mfsc_pkg::ACT_FRAME;
                    end
                end
            end
        end
    end

    // result made directly by an accepted byte
    always_comb
    begin
        acc_res = '0;
        acc_res.last = 1'b1;
        if (action == mfsc_pkg::ACT_FRAME)
        begin
            acc_res.kind                = 1'b1;
            acc_res.frame_command       = hdr_reg[15:8];
            acc_res.frame_sequence      = hdr_reg[63:32];
            acc_res.frame_length        = hdr_reg[22:16];
            acc_res.frame_first_payload = (hdr_len != 16'd0) ? first_reg : 8'd0;
        end
        else
        begin
            acc_res.pass_data  = {24'b0, rx_byte};
            acc_res.pass_count = 3'd1;
        end
    end

    // replay packer, four bytes per result
    always_comb
    begin
        if (rd_lane_reg == 2'd0)
        begin
            pack_next = {24'b0, rd_byte_reg};
        end
        else
        begin
            pack_next = pack_reg | ({24'b0, rd_byte_reg} << (8 * rd_lane_reg));
        end
        rep_res            = '0;
        rep_res.pass_data  = pack_next;
        rep_res.pass_count = {1'b0, rd_lane_reg} + 3'd1;
        rep_res.last       = rd_last_reg;
    end

    assign push     = (cmd.accept && (action == mfsc_pkg::ACT_PASS
                                      || action == mfsc_pkg::ACT_FRAME))
                      || (rd_vld_reg && rd_end_reg);
    assign push_res = (rd_vld_reg && rd_end_reg) ? rep_res : acc_res;

    // status toward the controller
    always_comb
    begin
        stat.action         = action;
        stat.rd_group_start = (rd_addr_reg[1:0] == 2'd0);
        stat.rd_group_end   = (rd_addr_reg[1:0] == 2'd3) || rd_last;
        stat.rd_done        = (rd_addr_reg == replay_len_reg);
    end

    // held byte memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && mem_we)
        begin
            mem[held_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_byte_reg <= mem[rd_addr_reg[ADDR_W-1:0]];
        end
    end

    // frame control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            crc_reg        <= mfsc_pkg::CRC_INIT;
            rd_vld_reg     <= 1'b0;
            rd_addr_reg    <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                held_count_reg <= held_count_next;
                crc_reg        <= crc_next;
            end
            rd_vld_reg <= cmd.rd_issue;
            if (cmd.accept && action == mfsc_pkg::ACT_REPLAY)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                rd_addr_reg <= rd_addr_reg + CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            frame_total_reg <= frame_total_next;
            replay_len_reg  <= replay_len_next;
            hdr_reg         <= hdr_next;
            tail_reg        <= tail_next;
            first_reg       <= first_next;
        end
        if (cmd.rd_issue)
        begin
            rd_lane_reg <= rd_addr_reg[1:0];
            rd_end_reg  <= (rd_addr_reg[1:0] == 2'd3) || rd_last;
            rd_last_reg <= rd_last;
        end
        if (rd_vld_reg)
        begin
            pack_reg <= pack_next;
        end
    end

`ifndef SYNTH
    // reads stay inside the replayed run
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (rd_addr_reg < replay_len_reg))
        else $error("replay read past held bytes");

    // an accepted frame restarts the search
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && action == mfsc_pkg::ACT_FRAME) |=> (held_count_reg == '0))
        else $error("held count not cleared after frame");
`endif

endmodule

/* bench/testbench.sv */
// self-checking bench for the magic frame sniffer with crc-32 check
// depends on mfsc_pkg and magic_frame_sniffer_crc32_unit; drives bytes, checks results
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_PAYLOAD  = 64;
    localparam int HOLD_DEPTH   = MAX_PAYLOAD + 20;
    localparam int RANDOM_BYTES = 70;
    localparam int IDLE_PCT     = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [7:0] MAGIC_SEQ [0:7] =
        '{8'hA5, 8'h5A, 8'h45, 8'h53, 8'h43, 8'h33, 8'h32, 8'h21};

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_MAGIC,
        ROW_FRAME,
        ROW_BAD_CRC
    } row_op_t;

    // one directed row: a byte, a magic prefix or a whole frame
    typedef struct packed {
        row_op_t         op;
        logic [7:0]      arg;     // byte value, prefix length or version
        logic [7:0]      cmd;
        logic [15:0]     len;
        logic [31:0]     seq;
        logic            typed;
        mfsc_pkg::res_t  known;   // result typed in for the last byte of the row
    } dir_row_t;

    // one entry of the byte stream toward the block
    typedef struct packed {
        logic [7:0]      b;
        logic            pause;    // wait for every owed result before going on
        logic            typed;
        mfsc_pkg::res_t  known;
    } rx_item_t;

    localparam int DIR_ROWS = 21;

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        // lone bytes at both extremes pass straight through
        '{ROW_BYTE,    8'h00, 8'h00, 16'd0,      32'h0, 1'b1,
          '{1'b0, 32'h0000_0000, 3'd1, 8'h0, 32'h0, 7'd0, 8'h0, 1'b1}},
        '{ROW_BYTE,    8'hFF, 8'h00, 16'd0,      32'h0, 1'b1,
          '{1'b0, 32'h0000_00FF, 3'd1, 8'h0, 32'h0, 7'd0, 8'h0, 1'b1}},
        // magic broken on its second byte
        '{ROW_BYTE,    8'hA5, 8'h00, 16'd0,      32'h0, 1'b0, '0},
        '{ROW_BYTE,    8'h00, 8'h00, 16'd0,      32'h0, 1'b1,
          '{1'b0, 32'h0000_00A5, 3'd2, 8'h0, 32'h0, 7'd0, 8'h0, 1'b1}},
        // magic broken by a first magic byte restarts it
        '{ROW_BYTE,    8'hA5, 8'h00, 16'd0,      32'h0, 1'b0, '0},
        '{ROW_BYTE,    8'hA5, 8'h00, 16'd0,      32'h0, 1'b1,
          '{1'b0, 32'h0000_00A5, 3'd1, 8'h0, 32'h0, 7'd0, 8'h0, 1'b1}},
        '{ROW_BYTE,    8'h00, 8'h00, 16'd0,      32'h0, 1'b0, '0},
        // seven magic bytes then a break: eight bytes in two results
        '{ROW_MAGIC,   8'd7,  8'h00, 16'd0,      32'h0, 1'b0, '0},
        '{ROW_BYTE,    8'h00, 8'h00, 16'd0,      32'h0, 1'b0, '0},
        // restart deep inside the magic
        '{ROW_MAGIC,   8'd3,  8'h00, 16'd0,      32'h0, 1'b0, '0},
        '{ROW_BYTE,    8'hA5, 8'h00, 16'd0,      32'h0, 1'b0, '0},
        '{ROW_BYTE,    8'h5A, 8'h00, 16'd0,      32'h0, 1'b0, '0},
        '{ROW_BYTE,    8'hFF, 8'h00, 16'd0,      32'h0, 1'b0, '0},
        // good frames, empty payload and extreme fields
        '{ROW_FRAME,   8'h01, 8'h00, 16'd0,      32'h0, 1'b1,
          '{1'b1, 32'h0, 3'd0, 8'h00, 32'h0, 7'd0, 8'h0, 1'b1}},
        '{ROW_FRAME,   8'h01, 8'hFF, 16'd1,      32'hFFFF_FFFF, 1'b0, '0},
        // bad header: version and length
        '{ROW_FRAME,   8'h00, 8'h11, 16'd0,      32'h0, 1'b0, '0},
        '{ROW_FRAME,   8'hFF, 8'h22, 16'd3,      32'h0, 1'b0, '0},
        '{ROW_FRAME,   8'h01, 8'h33, 16'd65,     32'h0, 1'b0, '0},
        '{ROW_FRAME,   8'h01, 8'h44, 16'hFFFF,   32'h0, 1'b0, '0},
        // crc mismatch, then the largest payload
        '{ROW_BAD_CRC, 8'h01, 8'h5A, 16'd2,      32'h8000_0001, 1'b0, '0},
        '{ROW_FRAME,   8'h01, 8'hA5, 16'd64,     32'h1234_5678, 1'b0, '0}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mfsc_pkg::TDATA_W-1:0]   m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    // byte stream, results owed by the block, and the request in flight
    rx_item_t        rx_stream [$];
    mfsc_pkg::res_t  owed_results [$];
    mfsc_pkg::res_t  new_results [$];
    logic [7:0]      replay_q [$];
    logic            cur_typed;
    mfsc_pkg::res_t  cur_known;

    int mismatches;
    int bytes_taken;
    int calm_from;
    int calm_to;
    int hold_at;
    int stall_count;

    // sniffer model state
    int          hold_n;
    int          frame_end;
    logic [7:0]  held [0:HOLD_DEPTH-1];
    logic [31:0] run_crc;
    logic [63:0] hdr;

    wire calm = (bytes_taken >= calm_from) && (bytes_taken < calm_to);

    magic_frame_sniffer_crc32_unit #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // reflected crc-32, one bit per pass
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'b0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = (r >> 1) ^ (mfsc_pkg::CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

    task automatic restart_sniffer();
        hold_n    = 0;
        frame_end = 0;
        run_crc   = mfsc_pkg::CRC_INIT;
        hdr       = '0;
    endtask

    // pack replayed bytes four to a result, remainder last
    task automatic pack_replay();
        mfsc_pkg::res_t r;
        int             n;
        n = 0;
        r = '0;
        while (replay_q.size() > 0)
        begin
            if (n == 0)
                r = '0;
            r.pass_data[8*n +: 8] = replay_q.pop_front();
            n++;
            if (n == 4 || replay_q.size() == 0)
            begin
                r.pass_count = n[2:0];
                r.last       = (replay_q.size() == 0);
                new_results.push_back(r);
                n = 0;
            end
        end
    endtask

    task automatic release_held();
        for (int k = 0; k < hold_n; k++)
            replay_q.push_back(held[k]);
        restart_sniffer();
        pack_replay();
    endtask

    // advance the sniffer by one byte, results go to new_results
    task automatic sniff_byte(input logic [7:0] b);
        logic [31:0]    crc_rx;
        mfsc_pkg::res_t fr;
        replay_q.delete();
        new_results.delete();
        if (hold_n < mfsc_pkg::MAGIC_LEN)
        begin
            if (b == MAGIC_SEQ[hold_n])
            begin
                held[hold_n] = b;
                hold_n++;
            end
            else
            begin
                for (int k = 0; k < hold_n; k++)
                    replay_q.push_back(held[k]);
                if (hold_n > 0 && b == MAGIC_SEQ[0])
                begin
                    restart_sniffer();
                    held[0] = b;
                    hold_n  = 1;
                end
                else
                begin
                    restart_sniffer();
                    replay_q.push_back(b);
                end
                pack_replay();
            end
        end
        else
        begin
            held[hold_n] = b;
            hold_n++;
            if (hold_n <= mfsc_pkg::HEAD_END)
            begin
                run_crc = crc_step(run_crc, b);
                hdr[8*(hold_n-mfsc_pkg::MAGIC_LEN-1) +: 8] = b;
                if (hold_n == mfsc_pkg::HEAD_END)
                begin
                    if (hdr[7:0] != mfsc_pkg::PROTO_VERSION || hdr[31:16] > MAX_PAYLOAD)
                        release_held();
                    else
                        frame_end = mfsc_pkg::HEAD_END + int'(hdr[31:16]) + mfsc_pkg::CRC_LEN;
                end
            end
            else
            begin
                if (hold_n <= frame_end - mfsc_pkg::CRC_LEN)
                    run_crc = crc_step(run_crc, b);
                if (hold_n == frame_end)
                begin
                    crc_rx = {held[frame_end-1], held[frame_end-2],
                              held[frame_end-3], held[frame_end-4]};
                    if (~run_crc != crc_rx)
                        release_held();
                    else
                    begin
                        fr                     = '0;
                        fr.kind                = 1'b1;
                        fr.frame_command       = hdr[15:8];
                        fr.frame_sequence      = hdr[63:32];
                        fr.frame_length        = hdr[22:16];
                        fr.frame_first_payload = (hdr[31:16] != 0)
                                                 ? held[mfsc_pkg::HEAD_END] : 8'h00;
                        fr.last                = 1'b1;
                        new_results.push_back(fr);
                        restart_sniffer();
                    end
                end
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic typed,
                              input mfsc_pkg::res_t known);
        rx_item_t it;
        it.b     = b;
        it.pause = 1'b0;
        it.typed = typed;
        it.known = known;
        rx_stream.push_back(it);
    endtask

    task automatic queue_pause();
        rx_item_t it;
        it       = '0;
        it.pause = 1'b1;
        rx_stream.push_back(it);
    endtask

    // magic, header and, for a sound header, payload and crc
    task automatic queue_frame(input logic [7:0] ver, input logic [7:0] cmd,
                               input logic [15:0] len, input logic [31:0] seq,
                               input logic bad_crc, input logic typed,
                               input mfsc_pkg::res_t known);
        logic [7:0]  body [$];
        logic [31:0] c;
        body = '{ver, cmd, len[7:0], len[15:8], seq[7:0], seq[15:8], seq[23:16], seq[31:24]};
        if (ver == mfsc_pkg::PROTO_VERSION && len <= MAX_PAYLOAD)
        begin
            repeat (int'(len))
                body.push_back(8'($urandom_range(255)));
            c = mfsc_pkg::CRC_INIT;
            foreach (body[k])
                c = crc_step(c, body[k]);
            c = ~c;
            if (bad_crc)
                c = c ^ (32'd1 << $urandom_range(31));
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
            body.push_back(c[23:16]);
            body.push_back(c[31:24]);
        end
        for (int k = 0; k < mfsc_pkg::MAGIC_LEN; k++)
            queue_byte(MAGIC_SEQ[k], 1'b0, '0);
        foreach (body[k])
            queue_byte(body[k], typed && (k == body.size() - 1), known);
    endtask

    // random sequences, mostly well-formed frames
    task automatic queue_random();
        int          start;
        int          pick;
        int          n;
        logic [7:0]  ver;
        logic [15:0] len;
        logic        paused;
        start  = rx_stream.size();
        paused = 1'b0;
        while (rx_stream.size() - start < RANDOM_BYTES)
        begin
            if (!paused && rx_stream.size() - start >= RANDOM_BYTES / 2)
            begin
                queue_pause();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? 16'($urandom_range(MAX_PAYLOAD))
                                            : 16'($urandom_range(8));
            if (pick < 55)
                queue_frame(mfsc_pkg::PROTO_VERSION, 8'($urandom), len, $urandom,
                            1'b0, 1'b0, '0);
            else if (pick < 65)
                queue_frame(mfsc_pkg::PROTO_VERSION, 8'($urandom), len, $urandom,
                            1'b1, 1'b0, '0);
            else if (pick < 72)
            begin
                ver = 8'($urandom_range(255));
                if (ver == mfsc_pkg::PROTO_VERSION)
                    ver = 8'h00;
                queue_frame(ver, 8'($urandom), len, $urandom, 1'b0, 1'b0, '0);
            end
            else if (pick < 79)
                queue_frame(mfsc_pkg::PROTO_VERSION, 8'($urandom),
                            16'($urandom_range(65535, 65)), $urandom, 1'b0, 1'b0, '0);
            else if (pick < 90)
            begin
                n = $urandom_range(7, 1);
                for (int k = 0; k < n; k++)
                    queue_byte(MAGIC_SEQ[k], 1'b0, '0);
                queue_byte(($urandom_range(1) == 0) ? mfsc_pkg::MAGIC_FIRST : 8'($urandom),
                           1'b0, '0);
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    queue_byte(8'($urandom), 1'b0, '0);
            end
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // checker: results first, then the byte taken at this edge
    always @(posedge clk)
    begin
        mfsc_pkg::res_t got;
        mfsc_pkg::res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind                = m_tuser;
                got.pass_data           = m_tdata[31:0];
                got.pass_count          = m_tdata[34:32];
                got.frame_command       = m_tdata[42:35];
                got.frame_sequence      = m_tdata[74:43];
                got.frame_length        = m_tdata[81:75];
                got.frame_first_payload = m_tdata[89:82];
                got.last                = m_tlast;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d data=%h cnt=%0d",
                             $time, got.kind, got.pass_data, got.pass_count);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected kind=%0d data=%h cnt=%0d cmd=%h",
                                 $time, want.kind, want.pass_data, want.pass_count,
                                 want.frame_command,
                                 " seq=%h len=%0d first=%h last=%0d", want.frame_sequence,
                                 want.frame_length, want.frame_first_payload, want.last,
                                 " | actual kind=%0d data=%h cnt=%0d cmd=%h", got.kind,
                                 got.pass_data, got.pass_count, got.frame_command,
                                 " seq=%h len=%0d first=%h last=%0d", got.frame_sequence,
                                 got.frame_length, got.frame_first_payload, got.last);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                sniff_byte(s_tdata);
                if (cur_typed)
                    owed_results.push_back(cur_known);
                else
                    foreach (new_results[k])
                        owed_results.push_back(new_results[k]);
                bytes_taken++;
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("%0t: no progress, %0d results owed", $time, owed_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random idling, a calm stretch and one long hold-off
    initial
    begin
        logic held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && bytes_taken >= hold_at)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // stimulus build, reset, sender and end of run
    initial
    begin
        rx_item_t it;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        cur_typed   = 1'b0;
        cur_known   = '0;
        mismatches  = 0;
        bytes_taken = 0;
        stall_count = 0;
        restart_sniffer();

        // directed table, then random sequences
        foreach (dir_tab[r])
        begin
            case (dir_tab[r].op)
                ROW_BYTE:
                    queue_byte(dir_tab[r].arg, dir_tab[r].typed, dir_tab[r].known);
                ROW_MAGIC:
                    for (int k = 0; k < dir_tab[r].arg; k++)
                        queue_byte(MAGIC_SEQ[k], 1'b0, '0);
                ROW_FRAME, ROW_BAD_CRC:
                    queue_frame(dir_tab[r].arg, dir_tab[r].cmd, dir_tab[r].len,
                                dir_tab[r].seq, dir_tab[r].op == ROW_BAD_CRC,
                                dir_tab[r].typed, dir_tab[r].known);
                default: ;
            endcase
        end
        queue_pause();
        calm_from = rx_stream.size() + 10;
        calm_to   = calm_from + 50;
        // hold off from the first request so the opening pass bytes fill the queue
        hold_at   = 0;
        queue_random();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rx_stream[i])
        begin
            it = rx_stream[i];
            @(negedge clk);
            if (it.pause)
            begin
                // sender waits for the block to drain completely
                s_tvalid <= 1'b0;
                while (owed_results.size() != 0)
                    @(negedge clk);
                repeat (DRAIN_CYCLES) @(negedge clk);
            end
            else
            begin
                while (!calm && $urandom_range(99) < IDLE_PCT)
                begin
                    s_tvalid <= 1'b0;
                    @(negedge clk);
                end
                s_tvalid  <= 1'b1;
                s_tdata   <= it.b;
                cur_typed <= it.typed;
                cur_known <= it.known;
                do
                    @(posedge clk);
                while (!s_tready);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
